// ----- design/morse_tone_symbol_receiver_macros.svh -----
// assertion macros for the morse tone symbol receiver
`ifndef MORSE_TONE_SYMBOL_RECEIVER_MACROS_SVH
`define MORSE_TONE_SYMBOL_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF

`define MTSR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define MTSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MTSR_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define MTSR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- design/mtsr_pkg.sv -----
// types, constants and code table for the morse tone symbol receiver
`timescale 1ns / 1ps

package mtsr_pkg;

  localparam int CNT_W     = 16;
  localparam int CODE_W    = 8;
  localparam int VALUE_W   = 4;
  localparam int SLOT_W    = 6;
  localparam int PHASE_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DOT_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAR_GAP = 2'd3;

  localparam logic [CNT_W-1:0] DOT_MIN_RESET  = 16'd50;
  localparam logic [CNT_W-1:0] DASH_MIN_RESET = 16'd250;
  localparam logic [CNT_W-1:0] RELEASE_RESET  = 16'd4;
  localparam logic [CNT_W-1:0] CHAR_GAP_RESET = 16'd250;
  localparam logic [CNT_W-1:0] CNT_MAX        = 16'hffff;

  localparam logic [CODE_W-1:0]  CODE_EQUALS   = 8'h0f;
  localparam logic [VALUE_W-1:0] VALUE_UNKNOWN = 4'd15;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_READ = 3'd2,
    PH_GAP  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  function automatic logic [VALUE_W-1:0] decode_code(input logic [CODE_W-1:0] code);
    logic [VALUE_W-1:0] v;
    case (code)
      8'h20:   v = 4'd0;
      8'h30:   v = 4'd1;
      8'h38:   v = 4'd2;
      8'h3c:   v = 4'd3;
      8'h3e:   v = 4'd4;
      8'h3f:   v = 4'd5;
      8'h2f:   v = 4'd6;
      8'h27:   v = 4'd7;
      8'h23:   v = 4'd8;
      8'h21:   v = 4'd9;
      8'h0c:   v = 4'd10;
      8'h0e:   v = 4'd11;
      8'h0b:   v = 4'd12;
      8'h09:   v = 4'd13;
      8'h0f:   v = 4'd14;
      default: v = VALUE_UNKNOWN;
    endcase
    return v;
  endfunction

  function automatic logic [CODE_W-1:0] add_element(input logic [CODE_W-1:0] bits,
                                                    input logic bit_in);
    logic [CODE_W-1:0] base;
    base = (bits == '0) ? CODE_W'(1) : bits;
    return {base[CODE_W-2:0], bit_in};
  endfunction

endpackage

// ----- design/morse_tone_symbol_receiver.sv -----
// morse tone symbol receiver: pulse-width decoder with output register
`timescale 1ns / 1ps

// Takes one tone sample word per tick and returns exactly one result word per
// sample. Each sample is decoded in the cycle it is accepted, so a new sample
// can be accepted every cycle; the result sits in one output register, which
// the block keeps refilling as long as the downstream side does not stall.
// Timing registers (dot/dash minimum, release, character gap) are written
// through a plain write port; the user must write them only while idle, which
// the block itself does not enforce. Up to MAX_SYMS symbols are stored per
// reception; the equals code or a full buffer ends it until a restart.
`include "morse_tone_symbol_receiver_macros.svh"

module morse_tone_symbol_receiver #(
  parameter int MAX_SYMS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mtsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtsr_pkg::CNT_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            tone_level,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            sym_valid,
  output logic [mtsr_pkg::CODE_W-1:0]     sym_code,
  output logic [mtsr_pkg::VALUE_W-1:0]    sym_value,
  output logic [mtsr_pkg::SLOT_W-1:0]     sym_slot,
  output logic                            finished,
  output logic [mtsr_pkg::PHASE_W-1:0]    phase_now
);
  import mtsr_pkg::*;

  localparam logic [SLOT_W-1:0] MAX_SLOTS = SLOT_W'(MAX_SYMS);

  logic [CNT_W-1:0] dot_min_ticks, dash_min_ticks, release_ticks, char_gap_ticks;

  phase_t            phase, phase_next;
  logic              prev_level, prev_level_next;
  logic              fall_seen, fall_seen_next;
  logic [CNT_W-1:0]  ticks_since_fall, ticks_since_fall_next;
  logic [CNT_W-1:0]  ticks_since_rise, ticks_since_rise_next;
  logic [CODE_W-1:0] element_bits, element_bits_next;
  logic [SLOT_W-1:0] stored_count, stored_count_next;

  logic              res_valid;
  logic [CODE_W-1:0] res_code;
  logic [VALUE_W-1:0] res_value;
  logic [SLOT_W-1:0] res_slot;

  logic              accept;
  logic [CNT_W-1:0]  tsf_inc, tsr_inc;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_min_ticks  <= DOT_MIN_RESET;
      dash_min_ticks <= DASH_MIN_RESET;
      release_ticks  <= RELEASE_RESET;
      char_gap_ticks <= CHAR_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DOT_MIN:  dot_min_ticks  <= cfg_data;
        CFG_DASH_MIN: dash_min_ticks <= cfg_data;
        CFG_RELEASE:  release_ticks  <= cfg_data;
        CFG_CHAR_GAP: char_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tsf_inc = (ticks_since_fall == CNT_MAX) ? ticks_since_fall : ticks_since_fall + 1'b1;
  assign tsr_inc = (ticks_since_rise == CNT_MAX) ? ticks_since_rise : ticks_since_rise + 1'b1;

  always_comb begin
    phase_next            = phase;
    prev_level_next       = prev_level;
    fall_seen_next        = fall_seen;
    ticks_since_fall_next = tsf_inc;
    ticks_since_rise_next = tsr_inc;
    element_bits_next     = element_bits;
    stored_count_next     = stored_count;
    res_valid             = 1'b0;
    res_code              = '0;
    res_value             = '0;
    res_slot              = '0;

    if (restart) begin
      element_bits_next = '0;
      stored_count_next = '0;
      phase_next        = PH_WAIT;
    end else if (phase inside {PH_WAIT, PH_READ, PH_GAP}) begin
      if (tone_level == prev_level) begin
        if (fall_seen) begin
          if (phase == PH_READ && tsf_inc > release_ticks) begin
            phase_next = PH_GAP;
            if (tsr_inc >= dash_min_ticks) begin
              element_bits_next = add_element(element_bits, 1'b0);
            end else if (tsr_inc >= dot_min_ticks) begin
              element_bits_next = add_element(element_bits, 1'b1);
            end else begin
              phase_next = PH_WAIT;
            end
          end else if (phase == PH_GAP && tsf_inc >= char_gap_ticks) begin
            if (stored_count < MAX_SLOTS) begin
              res_valid         = 1'b1;
              res_code          = element_bits;
              res_value         = decode_code(element_bits);
              res_slot          = stored_count;
              stored_count_next = stored_count + 1'b1;
              phase_next        = (element_bits == CODE_EQUALS) ? PH_DONE : PH_WAIT;
            end else begin
              phase_next = PH_DONE;
            end
            element_bits_next = '0;
          end
        end
      end else begin
        prev_level_next = tone_level;
        if (tone_level) begin
          if (phase == PH_WAIT || phase == PH_GAP) begin
            phase_next            = PH_READ;
            ticks_since_rise_next = '0;
          end
        end else begin
          fall_seen_next        = 1'b1;
          ticks_since_fall_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      prev_level       <= 1'b0;
      fall_seen        <= 1'b0;
      ticks_since_fall <= '0;
      ticks_since_rise <= '0;
      element_bits     <= '0;
      stored_count     <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      prev_level       <= prev_level_next;
      fall_seen        <= fall_seen_next;
      ticks_since_fall <= ticks_since_fall_next;
      ticks_since_rise <= ticks_since_rise_next;
      element_bits     <= element_bits_next;
      stored_count     <= stored_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sym_valid <= res_valid;
      sym_code  <= res_code;
      sym_value <= res_value;
      sym_slot  <= res_slot;
      finished  <= (phase_next == PH_DONE);
      phase_now <= phase_next;
    end
  end

  `MTSR_ASSERT_IMPL(a_slot_in_range, clk, rst, out_valid && sym_valid, sym_slot < MAX_SLOTS)
  `MTSR_ASSERT_IMPL(a_finished_phase, clk, rst, out_valid, finished == (phase_now == PH_DONE))
  `MTSR_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, stored_count <= MAX_SLOTS)
  `MTSR_ASSERT_NEXT(a_done_holds, clk, rst, accept && !restart && phase == PH_DONE, phase == PH_DONE)
  `MTSR_ASSERT_NEXT(a_result_follows, clk, rst, accept, out_valid && phase_now == phase)

endmodule
